[src/pcv_pkg.sv]
package pcv_pkg;

	localparam int LATTICE_SIZE_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 20;

	// CORDIC datapath width, Q2.30 with headroom.
	localparam int CW = 34;
	// Angle divider: numerator and divisor widths.
	localparam int TNW = 63;
	localparam int TDW = 33;

	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0] INV_TWO_PI_Q34 = 32'd2734261102;

	typedef enum logic [2:0] {
		REG_CENTER_X      = 3'd0,
		REG_CENTER_Y      = 3'd1,
		REG_SHEET_WIDTH   = 3'd2,
		REG_HEIGHT_SPAN   = 3'd3,
		REG_TURN_PROGRESS = 3'd4,
		REG_CURL_RADIUS   = 3'd5
	} pcv_reg_t;

	// Per-vertex values that ride along the angle divider and CORDIC.
	typedef struct packed {
		logic        flat;
		logic        flip;
		logic [31:0] y;
		logic [31:0] xflat;
	} pcv_side_t;

	// Binary arctangent of 2^-i, 2^32 per turn.
	function automatic logic signed [CW-1:0] atan_step(input int i);
		logic signed [CW-1:0] v;
		case (i)
			0:  v = 34'sd536870912;
			1:  v = 34'sd316933406;
			2:  v = 34'sd167458907;
			3:  v = 34'sd85004756;
			4:  v = 34'sd42667331;
			5:  v = 34'sd21354465;
			6:  v = 34'sd10679838;
			7:  v = 34'sd5340245;
			8:  v = 34'sd2670163;
			9:  v = 34'sd1335087;
			10: v = 34'sd667544;
			11: v = 34'sd333772;
			12: v = 34'sd166886;
			13: v = 34'sd83443;
			14: v = 34'sd41722;
			15: v = 34'sd20861;
			16: v = 34'sd10430;
			17: v = 34'sd5215;
			18: v = 34'sd2608;
			19: v = 34'sd1304;
			20: v = 34'sd652;
			21: v = 34'sd326;
			22: v = 34'sd163;
			23: v = 34'sd81;
			24: v = 34'sd41;
			25: v = 34'sd20;
			26: v = 34'sd10;
			27: v = 34'sd5;
			28: v = 34'sd3;
			29: v = 34'sd1;
			30: v = 34'sd1;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[src/pcv_div.sv]
module pcv_div #(
	parameter int NW    = 8,
	parameter int DW    = 4,
	parameter int LANES = 1,
	parameter int SW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [LANES-1:0][NW-1:0]   num,
	input  logic [DW-1:0]              den,
	input  logic [SW-1:0]              side_in,
	output logic                       out_valid,
	output logic [LANES-1:0][NW-1:0]   quo,
	output logic [SW-1:0]              side_out
);

	// Restoring division, one quotient bit per stage. The numerator shifts out
	// of the top of nq while quotient bits shift in at the bottom.
	logic                      valid_s [NW+1];
	logic [LANES-1:0][NW-1:0]  nq_s    [NW+1];
	logic [LANES-1:0][DW-1:0]  rem_s   [NW+1];
	logic [DW-1:0]             den_s   [NW+1];
	logic [SW-1:0]             side_s  [NW+1];

	assign valid_s[0] = in_valid;
	assign nq_s[0]    = num;
	assign rem_s[0]   = '0;
	assign den_s[0]   = den;
	assign side_s[0]  = side_in;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [LANES-1:0][DW-1:0] rem_nx;
		logic [LANES-1:0][NW-1:0] nq_nx;

		always_comb begin
			logic [DW:0] trial;
			trial = '0;
			for (int l = 0; l < LANES; l++) begin
				trial = {rem_s[k][l], nq_s[k][l][NW-1]};
				if (trial >= {1'b0, den_s[k]}) begin
					rem_nx[l] = DW'(trial - {1'b0, den_s[k]});
					nq_nx[l]  = {nq_s[k][l][NW-2:0], 1'b1};
				end else begin
					rem_nx[l] = trial[DW-1:0];
					nq_nx[l]  = {nq_s[k][l][NW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k+1]   <= nq_nx;
				rem_s[k+1]  <= rem_nx;
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[NW];
	assign quo       = nq_s[NW];
	assign side_out  = side_s[NW];

endmodule

[src/pcv_cordic.sv]
module pcv_cordic #(
	parameter int STEPS = 20,
	parameter int SW    = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic signed [pcv_pkg::CW-1:0]  z_in,
	input  logic [SW-1:0]                  side_in,
	output logic                           out_valid,
	output logic signed [pcv_pkg::CW-1:0]  x_out,
	output logic signed [pcv_pkg::CW-1:0]  y_out,
	output logic [SW-1:0]                  side_out
);
	import pcv_pkg::*;

	logic                 valid_s [STEPS+1];
	logic signed [CW-1:0] x_s     [STEPS+1];
	logic signed [CW-1:0] y_s     [STEPS+1];
	logic signed [CW-1:0] z_s     [STEPS+1];
	logic [SW-1:0]        side_s  [STEPS+1];

	assign valid_s[0] = in_valid;
	assign x_s[0]     = GAIN_Q30;
	assign y_s[0]     = '0;
	assign z_s[0]     = z_in;
	assign side_s[0]  = side_in;

	// One rotation per stage; the residual angle sign picks the direction.
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic signed [CW-1:0] xn, yn, zn;

		always_comb begin
			if (!z_s[i][CW-1]) begin
				xn = x_s[i] - (y_s[i] >>> i);
				yn = y_s[i] + (x_s[i] >>> i);
				zn = z_s[i] - atan_step(i);
			end else begin
				xn = x_s[i] + (y_s[i] >>> i);
				yn = y_s[i] - (x_s[i] >>> i);
				zn = z_s[i] + atan_step(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]    <= xn;
				y_s[i+1]    <= yn;
				z_s[i+1]    <= zn;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = valid_s[STEPS];
	assign x_out     = x_s[STEPS];
	assign y_out     = y_s[STEPS];
	assign side_out  = side_s[STEPS];

endmodule

[src/page_curl_vertex_position_core.sv]
// Channel   Direction  Handshake            Payload
// vtx       in         vtx_valid/vtx_stall  row_index, col_index
// pos       out        pos_valid/pos_stall  pos_x, pos_y, pos_z, is_curled
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One vertex per cycle sustained while pos is not stalled. The pipeline length is set
// by the bit-per-stage arc-to-angle divider and the CORDIC; the lattice scaling takes
// three stages. Reset is asynchronous, active low; it empties the pipeline and loads
// the register defaults. A stall on pos with pos_valid high freezes every stage at
// once and raises vtx_stall.
module page_curl_vertex_position_core #(
	parameter int LATTICE_SIZE = pcv_pkg::LATTICE_SIZE_DEF,
	parameter int CORDIC_STEPS = pcv_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	output logic               vtx_stall,
	input  logic [3:0]         row_index,
	input  logic [3:0]         col_index,
	output logic               pos_valid,
	input  logic               pos_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [30:0]        pos_z,
	output logic               is_curled,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import pcv_pkg::*;

	localparam int LM  = LATTICE_SIZE - 1;
	localparam int LMW = $clog2(LATTICE_SIZE);
	localparam int NW  = LMW + 34;
	localparam int SDW = $bits(pcv_side_t);
	// Offset that keeps the signed lattice quotients non-negative.
	localparam longint KOFF  = longint'(1) << 30;
	localparam longint BIAS  = 2 * LM + KOFF * 4 * LM;
	localparam longint AHALF = 32768 * LM;
	localparam logic signed [CW-1:0] QTURN = CW'(longint'(1) << 30);
	// Lattice division by 4*LM: drop two bits, then a reciprocal product split in
	// two halves of the numerator.
	localparam int KW  = NW - 2;
	localparam int LOW = 18;
	localparam int HIW = KW - LOW;
	localparam int MW  = 34;
	localparam logic [MW-1:0] RECIP = MW'((longint'(1) << KW) / LM);

	// Configuration registers.
	logic signed [31:0] cx_q, cy_q, hs_q;
	logic [30:0]        w_q, r_q;
	logic [16:0]        p_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			w_q  <= 31'd65536;
			hs_q <= 32'sd65536;
			p_q  <= '0;
			r_q  <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X:      cx_q <= cfg_data;
				REG_CENTER_Y:      cy_q <= cfg_data;
				REG_SHEET_WIDTH:   w_q  <= cfg_data[30:0];
				REG_HEIGHT_SPAN:   hs_q <= cfg_data;
				REG_TURN_PROGRESS: p_q  <= cfg_data[16:0];
				REG_CURL_RADIUS:   r_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic [16:0] pc;
	logic [30:0] rr;
	assign pc = (p_q > 17'd65536) ? 17'd65536 : p_q;
	assign rr = (r_q == '0) ? 31'd1 : r_q;

	// Curl offset depends only on configuration; it is registered from the
	// configuration registers and is not gated by the pipeline enable.
	logic signed [17:0] half_m_p;
	logic signed [49:0] woff_prod;
	logic signed [32:0] xoff_q;
	assign half_m_p  = 18'sd32768 - $signed({1'b0, pc});
	assign woff_prod = $signed({1'b0, w_q}) * half_m_p;

	always_ff @(posedge clk) begin
		xoff_q <= 33'((woff_prod + 50'sd32768) >>> 16);
	end

	logic en;
	assign en        = !(pos_valid && pos_stall);
	assign vtx_stall = !en;

	// Stage 1: clamp indices, lattice products, flat test.
	logic [3:0]         row_c, col_c;
	logic signed [9:0]  tr, tc;
	logic signed [26:0] dv;
	logic signed [41:0] ny_c, nx_c;
	logic               flat_c;

	assign row_c  = (int'(row_index) > LM) ? 4'(LM) : row_index;
	assign col_c  = (int'(col_index) > LM) ? 4'(LM) : col_index;
	assign tr     = 10'(2 * int'(row_c) - LM);
	assign tc     = 10'(2 * int'(col_c) - LM);
	assign dv     = 27'(int'(col_c) * 65536 - (65536 - int'(pc)) * LM);
	assign flat_c = (w_q == '0) || (dv <= 0);
	assign ny_c   = tr * hs_q;
	assign nx_c   = tc * $signed({1'b0, w_q});

	logic               v_s1, flat_s1;
	logic signed [41:0] ny_s1, nx_s1;
	logic signed [26:0] d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vtx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ny_s1   <= ny_c;
			nx_s1   <= nx_c;
			d_s1    <= dv;
			flat_s1 <= flat_c;
		end
	end

	// Stage 2: arc product and biased numerators.
	logic [56:0]   wd_c;
	logic          v_s2, flat_s2;
	logic [56:0]   wd_s2;
	logic [NW-1:0] ny_s2, nx_s2;

	assign wd_c = w_q * d_s1[25:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wd_s2   <= flat_s1 ? '0 : wd_c;
			ny_s2   <= NW'(2 * longint'(ny_s1) + BIAS);
			nx_s2   <= NW'(2 * longint'(nx_s1) + BIAS);
			flat_s2 <= flat_s1;
		end
	end

	// Stage 3: arc numerator scaled onto the shared divisor 4*(LATTICE_SIZE-1).
	logic          v_s3, flat_s3;
	logic [NW-1:0] ny_s3, nx_s3, na_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s3   <= NW'(((longint'(wd_s2) + AHALF) >> 16) * 4);
			ny_s3   <= ny_s2;
			nx_s3   <= nx_s2;
			flat_s3 <= flat_s2;
		end
	end

	// Lattice stage 1: partial reciprocal products. Lane 0 is y, lane 1 flat x,
	// lane 2 the arc length.
	logic [2:0][KW-1:0]     nd_c;
	logic                   v_l1, flat_l1;
	logic [2:0][KW-1:0]     nd_l1;
	logic [2:0][HIW+MW-1:0] ph_l1;
	logic [2:0][LOW+MW-1:0] pl_l1;

	assign nd_c[0] = ny_s3[NW-1:2];
	assign nd_c[1] = nx_s3[NW-1:2];
	assign nd_c[2] = na_s3[NW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_l1 <= 1'b0;
		end else if (en) begin
			v_l1 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				nd_l1[l] <= nd_c[l];
				ph_l1[l] <= nd_c[l][KW-1:LOW] * RECIP;
				pl_l1[l] <= nd_c[l][LOW-1:0] * RECIP;
			end
			flat_l1 <= flat_s3;
		end
	end

	// Lattice stage 2: the estimate is the true quotient or one below it.
	logic [2:0][KW+MW-1:0] sum_c;
	logic                  v_l2, flat_l2;
	logic [2:0][KW-1:0]    nd_l2;
	logic [2:0][MW-1:0]    q0_l2;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sum_c[l] = {ph_l1[l], {LOW{1'b0}}} + (KW+MW)'(pl_l1[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_l2 <= 1'b0;
		end else if (en) begin
			v_l2 <= v_l1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				q0_l2[l] <= sum_c[l][KW+MW-1:KW];
				nd_l2[l] <= nd_l1[l];
			end
			flat_l2 <= flat_l1;
		end
	end

	// Lattice stage 3: bump the estimate when the remainder reaches the divisor.
	logic [2:0][KW-1:0] rem_c;
	logic               v_l3, flat_l3;
	logic [2:0][NW-1:0] q_l3;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rem_c[l] = nd_l2[l] - KW'(q0_l2[l]) * KW'(LM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_l3 <= 1'b0;
		end else if (en) begin
			v_l3 <= v_l2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				q_l3[l] <= (rem_c[l] >= KW'(LM)) ? NW'(q0_l2[l]) + NW'(1) : NW'(q0_l2[l]);
			end
			flat_l3 <= flat_l2;
		end
	end

	logic                 cv;
	logic [2:0][NW-1:0]   cq;
	logic [0:0]           cflat;

	assign cv    = v_l3;
	assign cq    = q_l3;
	assign cflat = flat_l3;

	// Stage c1: y and flat x finished, arc length times 1/(2*pi).
	logic [62:0]        m_c;
	logic               v_c1, flat_c1;
	logic signed [31:0] y_c1, xf_c1;
	logic [62:0]        m_c1;

	assign m_c = cq[2][30:0] * INV_TWO_PI_Q34;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1 <= 1'b0;
		end else if (en) begin
			v_c1 <= cv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_c1    <= sat32(longint'(cy_q) + longint'(cq[0]) - KOFF);
			xf_c1   <= sat32(longint'(cx_q) + longint'(cq[1]) - KOFF);
			m_c1    <= cflat[0] ? '0 : m_c;
			flat_c1 <= cflat[0];
		end
	end

	// Stage c2: rounding term for the angle division.
	logic           v_c2;
	logic [TNW-1:0] nt_c2;
	pcv_side_t      side_c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c2 <= 1'b0;
		end else if (en) begin
			v_c2 <= v_c1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nt_c2   <= m_c1 + TNW'({rr, 1'b0});
			side_c2 <= '{flat: flat_c1, flip: 1'b0, y: y_c1, xflat: xf_c1};
		end
	end

	logic                tv;
	logic [0:0][TNW-1:0] tq;
	pcv_side_t           tside;

	pcv_div #(
		.NW(TNW), .DW(TDW), .LANES(1), .SW(SDW)
	) u_ang_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_c2),
		.num      (nt_c2),
		.den      ({rr, 2'b00}),
		.side_in  (side_c2),
		.out_valid(tv),
		.quo      (tq),
		.side_out (tside)
	);

	// Stage t1: fold the angle into the right half plane.
	logic [31:0]          th, th_q1;
	logic                 flip_c;
	logic                 v_t1;
	logic signed [CW-1:0] cz_t1;
	pcv_side_t            side_t1;

	assign th     = tq[0][31:0];
	assign th_q1  = th + 32'h4000_0000;
	assign flip_c = th_q1[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t1 <= 1'b0;
		end else if (en) begin
			v_t1 <= tv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cz_t1   <= CW'($signed(flip_c ? th + 32'h8000_0000 : th));
			side_t1 <= '{flat: tside.flat, flip: flip_c, y: tside.y, xflat: tside.xflat};
		end
	end

	logic                 kv;
	logic signed [CW-1:0] kx, ky;
	pcv_side_t            kside;
	logic [SDW-1:0]       kside_in_c;

	assign kside_in_c = side_t1;

	pcv_cordic #(
		.STEPS(CORDIC_STEPS), .SW(SDW)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_t1),
		.z_in     (cz_t1),
		.side_in  (kside_in_c),
		.out_valid(kv),
		.x_out    (kx),
		.y_out    (ky),
		.side_out (kside)
	);

	// Stage b1: scale by the radius.
	logic               v_b1;
	logic signed [65:0] px_b1, pc_b1;
	pcv_side_t          side_b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
		end else if (en) begin
			v_b1 <= kv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_b1   <= $signed({1'b0, rr}) * ky;
			pc_b1   <= $signed({1'b0, rr}) * kx;
			side_b1 <= kside;
		end
	end

	// Stage b2: undo the fold and round from Q30.
	logic signed [65:0] pxf_c, pcf_c, rsh_c, tz_c;
	logic               v_b2;
	logic signed [35:0] sx_b2;
	logic signed [36:0] z_b2;
	pcv_side_t          side_b2;

	assign pxf_c = side_b1.flip ? -px_b1 : px_b1;
	assign pcf_c = side_b1.flip ? -pc_b1 : pc_b1;
	assign rsh_c = $signed({35'd0, rr}) <<< 30;
	assign tz_c  = rsh_c - pcf_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b2 <= 1'b0;
		end else if (en) begin
			v_b2 <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_b2   <= 36'((pxf_c + 66'sd536870912) >>> 30);
			z_b2    <= 37'((tz_c + 66'sd536870912) >>> 30);
			side_b2 <= side_b1;
		end
	end

	// Stage b3: output register.
	logic [30:0]        zc;
	logic signed [31:0] xc;
	logic               v_b3, curl_b3;
	logic signed [31:0] x_b3, y_b3;
	logic [30:0]        z_b3;

	assign xc = sat32(longint'(cx_q) + longint'(xoff_q) + longint'(sx_b2));

	always_comb begin
		if (z_b2 < 0) begin
			zc = '0;
		end else if (z_b2 > 37'sd2147483647) begin
			zc = 31'h7fff_ffff;
		end else begin
			zc = z_b2[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b3 <= 1'b0;
		end else if (en) begin
			v_b3 <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_b3    <= side_b2.y;
			x_b3    <= side_b2.flat ? side_b2.xflat : xc;
			z_b3    <= side_b2.flat ? '0 : zc;
			curl_b3 <= !side_b2.flat;
		end
	end

	assign pos_valid = v_b3;
	assign pos_x     = x_b3;
	assign pos_y     = y_b3;
	assign pos_z     = z_b3;
	assign is_curled = curl_b3;

`ifndef SYNTH
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid && pos_stall) |-> vtx_stall)
		else $error("held result did not stall the input");

	a_flat_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid && !is_curled) |-> (pos_z == '0))
		else $error("flat vertex with nonzero depth");

	a_curl_width: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid && is_curled) |-> (w_q != '0))
		else $error("curled vertex on a sheet of zero width");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_t1 |-> ((cz_t1 >= -QTURN) && (cz_t1 < QTURN)))
		else $error("folded angle outside the right half plane");
`endif

endmodule

[tb/page_curl_vertex_position_core_tb.sv]
`timescale 1ns / 1ps

module page_curl_vertex_position_core_tb;
	import pcv_pkg::*;

	localparam int LSIZE = LATTICE_SIZE_DEF;
	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam longint LM = LSIZE - 1;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 140;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [30:0]        z;
		logic               curled;
	} vertex_pos_t;

	class pos_board;
		vertex_pos_t pending[$];
		int unsigned errors;
		logic [31:0] cx, cy, hs;
		logic [30:0] w, r;
		logic [16:0] p;
		longint atan_tbl[32];

		function new();
			atan_tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
				41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
				5, 3, 1, 1, 0};
			errors = 0;
			cx = 0; cy = 0; w = 65536; hs = 65536; p = 0; r = 65536;
		endfunction

		function void set_reg(pcv_reg_t idx, logic [31:0] v);
			case (idx)
				REG_CENTER_X:      cx = v;
				REG_CENTER_Y:      cy = v;
				REG_SHEET_WIDTH:   w = v[30:0];
				REG_HEIGHT_SPAN:   hs = v;
				REG_TURN_PROGRESS: p = v[16:0];
				REG_CURL_RADIUS:   r = v[30:0];
				default: ;
			endcase
		endfunction

		function longint floor_div(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0) q--;
			return q;
		endfunction

		function longint round_div(longint n, longint d);
			return floor_div(2 * n + d, 2 * d);
		endfunction

		function longint round_shift(longint v, int s);
			return (v + (64'sd1 <<< (s - 1))) >>> s;
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function void note(logic [3:0] row_in, logic [3:0] col_in);
			longint row, col, scx, scy, shs, sw, sp, sr, x, y, z, d, cz, vx, vy, tx;
			longint unsigned den, arc, prod;
			logic [31:0] th;
			logic flip;
			vertex_pos_t e;
			row = row_in; col = col_in;
			if (row > LM) row = LM;
			if (col > LM) col = LM;
			scx = longint'($signed(cx));
			scy = longint'($signed(cy));
			shs = longint'($signed(hs));
			sw = longint'(w);
			sp = (p > 17'd65536) ? 65536 : longint'(p);
			sr = (r == 0) ? 1 : longint'(r);
			z = 0;
			e.curled = 1'b0;
			y = clip32(scy + round_div((2 * row - LM) * shs, 2 * LM));
			d = col * 65536 - (65536 - sp) * LM;
			if (sw == 0 || d <= 0) begin
				x = clip32(scx + round_div((2 * col - LM) * sw, 2 * LM));
			end else begin
				den = 65536 * LM;
				arc = (longint'(sw * d) + den / 2) / den;
				prod = arc * 64'd2734261102 + 2 * longint'(sr);
				th = 32'(prod / (4 * longint'(sr)));
				flip = th[31] ^ th[30];
				if (flip) th = th + 32'h80000000;
				cz = longint'($signed(th));
				vx = 652032874;
				vy = 0;
				for (int i = 0; i < STEPS && i < 32; i++) begin
					if (cz >= 0) begin
						tx = vx - (vy >>> i);
						vy = vy + (vx >>> i);
						cz -= atan_tbl[i];
					end else begin
						tx = vx + (vy >>> i);
						vy = vy - (vx >>> i);
						cz += atan_tbl[i];
					end
					vx = tx;
				end
				if (flip) begin
					vx = -vx;
					vy = -vy;
				end
				x = clip32(scx + round_shift(sw * (32768 - sp), 16) + round_shift(sr * vy, 30));
				z = round_shift(sr * ((64'sd1 <<< 30) - vx), 30);
				if (z < 0) z = 0;
				if (z > 64'sd2147483647) z = 64'sd2147483647;
				e.curled = 1'b1;
			end
			e.x = x[31:0];
			e.y = y[31:0];
			e.z = z[30:0];
			pending.push_back(e);
		endfunction

		function void check(vertex_pos_t got);
			vertex_pos_t e;
			if (pending.size() == 0) begin
				$error("position transfer with no vertex outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.x !== e.x) begin
				$error("pos_x expected %0d actual %0d", e.x, got.x);
				errors++;
			end
			if (got.y !== e.y) begin
				$error("pos_y expected %0d actual %0d", e.y, got.y);
				errors++;
			end
			if (got.z !== e.z) begin
				$error("pos_z expected %0d actual %0d", e.z, got.z);
				errors++;
			end
			if (got.curled !== e.curled) begin
				$error("is_curled expected %0d actual %0d", e.curled, got.curled);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic vtx_valid, vtx_stall, pos_valid, pos_stall, is_curled, cfg_valid, cfg_ready;
	logic [3:0] row_index, col_index;
	logic signed [31:0] pos_x, pos_y;
	logic [30:0] pos_z;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	pos_board board;
	bit quiet;
	int idle_count;
	int stall_burst;

	page_curl_vertex_position_core uut (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
		.row_index(row_index), .col_index(col_index),
		.pos_valid(pos_valid), .pos_stall(pos_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .is_curled(is_curled),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Monitor and watchdog: both sample at the rising edge.
	always @(posedge clk) begin
		vertex_pos_t got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (vtx_valid && !vtx_stall) begin
				board.note(row_index, col_index);
				moved = 1'b1;
			end
			if (pos_valid && !pos_stall) begin
				got.x = pos_x; got.y = pos_y; got.z = pos_z; got.curled = is_curled;
				board.check(got);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) moved = 1'b1;
			if (moved) begin
				idle_count <= 0;
			end else begin
				idle_count <= idle_count + 1;
			end
			if (idle_count >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Receiver back-pressure in random bursts.
	always @(negedge clk) begin
		if (stall_burst > 0) begin
			stall_burst = stall_burst - 1;
			pos_stall = 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_burst = $urandom_range(0, 3);
			pos_stall = 1'b1;
		end else begin
			pos_stall = 1'b0;
		end
	end

	task automatic write_reg(pcv_reg_t idx, logic [31:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	task automatic load_setup(logic [31:0] cx, logic [31:0] cy, logic [31:0] w,
			logic [31:0] hs, logic [31:0] p, logic [31:0] r);
		wait_drained();
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_SHEET_WIDTH, w);
		write_reg(REG_HEIGHT_SPAN, hs);
		write_reg(REG_TURN_PROGRESS, p);
		write_reg(REG_CURL_RADIUS, r);
	endtask

	// Holds valid across consecutive transfers; drops it only for a gap.
	task automatic send_vertex(logic [3:0] row, logic [3:0] col);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			vtx_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		vtx_valid = 1'b1;
		row_index = row;
		col_index = col;
		do @(posedge clk); while (vtx_stall);
	endtask

	task automatic end_burst();
		@(negedge clk);
		vtx_valid = 1'b0;
	endtask

	task automatic corner_sweep();
		send_vertex(4'd0, 4'd0);
		send_vertex(4'd15, 4'd15);
		send_vertex(4'd0, 4'd15);
		send_vertex(4'd15, 4'd0);
		send_vertex(4'd7, 4'd8);
		send_vertex(4'd10, 4'd5);
		end_burst();
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_width();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'h7fffffff;
			2: return $urandom & 32'h7fffffff;
			default: return $urandom_range(1, 32'h01000000);
		endcase
	endfunction

	function automatic logic [31:0] pick_progress();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd65536;
			2: return $urandom_range(65537, 131071);
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	function automatic logic [31:0] pick_radius();
		case ($urandom_range(0, 6))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'h7fffffff;
			3: return $urandom & 32'h7fffffff;
			default: return $urandom_range(256, 32'h00400000);
		endcase
	endfunction

	initial begin
		int n;
		board = new();
		quiet = 1'b0;
		idle_count = 0;
		stall_burst = 0;
		arst_n = 1'b0;
		vtx_valid = 1'b0;
		row_index = '0;
		col_index = '0;
		pos_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CENTER_X;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset values, then fully turned, progress above one, zero radius,
		// zero width and saturation of every output.
		corner_sweep();
		load_setup(32'h0, 32'h0, 32'h00040000, 32'h00020000, 32'd65536, 32'h00010000);
		corner_sweep();
		load_setup(32'h00010000, 32'hffff0000, 32'h00080000, 32'h00010000, 32'd131071, 32'd0);
		corner_sweep();
		load_setup(32'h7fffffff, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'd40000, 32'd1);
		corner_sweep();
		load_setup(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'd32768,
			32'h7fffffff);
		send_vertex(4'd15, 4'd15);
		send_vertex(4'd0, 4'd12);
		end_burst();

		for (int ph = 0; ph < 14; ph++) begin
			if (ph == 13) quiet = 1'b1;
			load_setup(pick32(), pick32(), pick_width(), pick32(), pick_progress(),
				pick_radius());
			n = 100;
			for (int k = 0; k < n; k++) begin
				send_vertex(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
				if (ph == 4 && k == 50) begin
					end_burst();
					wait_drained();
				end
			end
			end_burst();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[page_curl_vertex_position_core.f]
src/pcv_pkg.sv
src/pcv_div.sv
src/pcv_cordic.sv
src/page_curl_vertex_position_core.sv
tb/page_curl_vertex_position_core_tb.sv
